FILE: hdl/sqsr_pkg.sv
// Shared types and constants for the stack/queue search-and-remove block.
// No dependencies; used by every module under hdl/.
`default_nettype none

package sqsr_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 4;
  // Wide enough for a count or position at the largest supported depth (64).
  localparam int ARG_W     = 7;

  localparam logic STORE_STACK = 1'b0;
  localparam logic STORE_QUEUE = 1'b1;

  typedef enum logic [1:0] {
    KIND_ADD,
    KIND_REMOVE,
    KIND_FIND,
    KIND_LIST
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_EMPTY,
    ST_NOT_FOUND,
    ST_FULL
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_TOP,
    OP_PUSH_AT,
    OP_ROTATE,
    OP_REMOVE
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_REPORT,
    S_LIST
  } state_t;

  typedef struct packed {
    cell_op_t          op;
    logic [ARG_W-1:0]  arg;
    logic [DATA_W-1:0] data;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/sqsr_cell.sv
// One storage cell of a store row: holds a single entry and moves it to or
// from its neighbors on a row command. Depends on sqsr_pkg.
`default_nettype none

module sqsr_cell #(
  parameter int IDX = 0
) (
  input  wire                         clk,
  input  sqsr_pkg::cmd_t              cmd_i,
  input  wire [sqsr_pkg::DATA_W-1:0]  prev_i,
  input  wire [sqsr_pkg::DATA_W-1:0]  next_i,
  input  wire [sqsr_pkg::DATA_W-1:0]  head_i,
  output logic [sqsr_pkg::DATA_W-1:0] val_o
);

  localparam logic [sqsr_pkg::ARG_W-1:0] MY_POS = sqsr_pkg::ARG_W'(IDX);

  logic [sqsr_pkg::DATA_W-1:0] val_r;
  logic [sqsr_pkg::DATA_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    case (cmd_i.op)
      sqsr_pkg::OP_PUSH_TOP: val_nxt = prev_i;
      sqsr_pkg::OP_PUSH_AT: begin
        if (MY_POS == cmd_i.arg) val_nxt = cmd_i.data;
      end
      // arg is the last occupied position; the head wraps around to it
      sqsr_pkg::OP_ROTATE: begin
        if (MY_POS == cmd_i.arg) val_nxt = head_i;
        else if (MY_POS < cmd_i.arg) val_nxt = next_i;
      end
      sqsr_pkg::OP_REMOVE: begin
        if (MY_POS >= cmd_i.arg) val_nxt = next_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_o = val_r;

endmodule

`default_nettype wire

FILE: hdl/sqsr_row.sv
// A row of DEPTH cells forming one store, position 0 at the top/head, plus
// its fill count. Depends on sqsr_pkg and sqsr_cell.
`default_nettype none

module sqsr_row #(
  parameter int DEPTH = sqsr_pkg::DEPTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  sqsr_pkg::cmd_t                     cmd_i,
  output logic [sqsr_pkg::DATA_W-1:0]        head_o,
  output logic [$clog2(DEPTH+1)-1:0]         count_o
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]               count_r;
  logic [CW-1:0]               count_nxt;
  sqsr_pkg::cmd_t              cell_cmd;
  logic [sqsr_pkg::DATA_W-1:0] vals [DEPTH];

  // Window-relative arguments come from the local count.
  always_comb begin
    cell_cmd = cmd_i;
    case (cmd_i.op)
      sqsr_pkg::OP_PUSH_AT: cell_cmd.arg = sqsr_pkg::ARG_W'(count_r);
      sqsr_pkg::OP_ROTATE:
        cell_cmd.arg = sqsr_pkg::ARG_W'(count_r) - sqsr_pkg::ARG_W'(1);
      default: ;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    case (cmd_i.op) inside
      sqsr_pkg::OP_PUSH_TOP, sqsr_pkg::OP_PUSH_AT: count_nxt = count_r + CW'(1);
      sqsr_pkg::OP_REMOVE:                         count_nxt = count_r - CW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic [sqsr_pkg::DATA_W-1:0] prev_v;
      logic [sqsr_pkg::DATA_W-1:0] next_v;
      if (i == 0) begin : g_first
        assign prev_v = cmd_i.data;
      end else begin : g_mid
        assign prev_v = vals[i-1];
      end
      if (i == DEPTH - 1) begin : g_end
        assign next_v = vals[i];
      end else begin : g_inner
        assign next_v = vals[i+1];
      end
      sqsr_cell #(.IDX(i)) u_cell (
        .clk    (clk),
        .cmd_i  (cell_cmd),
        .prev_i (prev_v),
        .next_i (next_v),
        .head_i (vals[0]),
        .val_o  (vals[i])
      );
    end
  endgenerate

  assign head_o  = vals[0];
  assign count_o = count_r;

endmodule

`default_nettype wire

FILE: hdl/stack_queue_search_remove.sv
// Stack and queue with search, remove-by-value and listing, built on two
// rows of shifting cells. Depends on sqsr_pkg and sqsr_row.
//
// Usage: the input channel (in_valid/in_stall) takes one item at a time:
// in_kind selects add, remove, find or list, in_which_store picks stack (0)
// or queue (1), in_value is the value to add or look for. Results leave on
// the out_ channel; out_last marks the final result of an item.
// Steps of each item after acceptance, n the entry count of the selected store:
//   add, or any request on an empty store: the result is loaded from EXEC.
//   find / remove: SCAN, then REPORT loads the result. The row rotates once
//   per cycle past the compare at cell 0, a full turn of n rotations.
//   list: one result per cycle as the row rotates, while the output is not
//   stalled, n results in all.
// in_stall is high from acceptance until the item's last result is loaded
// into the output register, so a new item may enter while that result waits.
// When out_stall is high the output holds; a list pauses its rotation and a
// search waits in its report step. Reset clears both counts and the control
// state; entry contents are not cleared and are only read below the count.
`default_nettype none

module stack_queue_search_remove #(
  parameter int DEPTH = sqsr_pkg::DEPTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire [1:0]                           in_kind,
  input  wire                                 in_which_store,
  input  wire signed [sqsr_pkg::DATA_W-1:0]   in_value,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [1:0]                          out_status,
  output logic [sqsr_pkg::POS_W-1:0]          out_position,
  output logic signed [sqsr_pkg::DATA_W-1:0]  out_entry_value,
  output logic                                out_last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  sqsr_pkg::state_t            state_r, state_nxt;
  sqsr_pkg::kind_t             kind_r;
  logic                        sel_r;
  logic [sqsr_pkg::DATA_W-1:0] key_r;
  logic [CW-1:0]               step_r, step_nxt;
  logic                        found_r, found_nxt;
  logic [CW-1:0]               fpos_r, fpos_nxt;
  logic [sqsr_pkg::DATA_W-1:0] fval_r, fval_nxt;

  logic                        out_valid_r;
  logic [1:0]                  out_status_r;
  logic [sqsr_pkg::POS_W-1:0]  out_position_r;
  logic [sqsr_pkg::DATA_W-1:0] out_value_r;
  logic                        out_last_r;
  logic                        out_load;
  sqsr_pkg::status_t           out_status_nxt;
  logic [sqsr_pkg::POS_W-1:0]  out_position_nxt;
  logic [sqsr_pkg::DATA_W-1:0] out_value_nxt;
  logic                        out_last_nxt;

  sqsr_pkg::cmd_t              cmd;
  sqsr_pkg::cmd_t              hold_cmd;
  sqsr_pkg::cmd_t              stk_cmd;
  sqsr_pkg::cmd_t              que_cmd;
  logic [sqsr_pkg::DATA_W-1:0] stk_head, que_head, head;
  logic [CW-1:0]               stk_cnt, que_cnt, n;
  logic                        in_accept;
  logic                        out_free;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != sqsr_pkg::S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  assign head = (sel_r == sqsr_pkg::STORE_QUEUE) ? que_head : stk_head;
  assign n    = (sel_r == sqsr_pkg::STORE_QUEUE) ? que_cnt : stk_cnt;

  always_comb begin
    hold_cmd      = '0;
    hold_cmd.op   = sqsr_pkg::OP_HOLD;
    stk_cmd       = (sel_r == sqsr_pkg::STORE_STACK) ? cmd : hold_cmd;
    que_cmd       = (sel_r == sqsr_pkg::STORE_QUEUE) ? cmd : hold_cmd;
  end

  sqsr_row #(.DEPTH(DEPTH)) u_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd_i   (stk_cmd),
    .head_o  (stk_head),
    .count_o (stk_cnt)
  );

  sqsr_row #(.DEPTH(DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd_i   (que_cmd),
    .head_o  (que_head),
    .count_o (que_cnt)
  );

  always_comb begin
    state_nxt        = state_r;
    step_nxt         = step_r;
    found_nxt        = found_r;
    fpos_nxt         = fpos_r;
    fval_nxt         = fval_r;
    cmd              = '0;
    cmd.op           = sqsr_pkg::OP_HOLD;
    out_load         = 1'b0;
    out_status_nxt   = sqsr_pkg::ST_OK;
    out_position_nxt = '0;
    out_value_nxt    = '0;
    out_last_nxt     = 1'b1;
    unique case (state_r)
      sqsr_pkg::S_IDLE: begin
        if (in_valid) state_nxt = sqsr_pkg::S_EXEC;
      end
      sqsr_pkg::S_EXEC: begin
        if (kind_r == sqsr_pkg::KIND_ADD) begin
          if (out_free) begin
            out_load  = 1'b1;
            state_nxt = sqsr_pkg::S_IDLE;
            if (n == FULL_CNT) begin
              out_status_nxt = sqsr_pkg::ST_FULL;
            end else begin
              cmd.op        = (sel_r == sqsr_pkg::STORE_QUEUE) ? sqsr_pkg::OP_PUSH_AT
                                                               : sqsr_pkg::OP_PUSH_TOP;
              cmd.data      = key_r;
              out_value_nxt = key_r;
              if (sel_r == sqsr_pkg::STORE_QUEUE) out_position_nxt = sqsr_pkg::POS_W'(n);
            end
          end
        end else if (n == '0) begin
          if (out_free) begin
            out_load       = 1'b1;
            out_status_nxt = sqsr_pkg::ST_EMPTY;
            state_nxt      = sqsr_pkg::S_IDLE;
          end
        end else if (kind_r == sqsr_pkg::KIND_LIST) begin
          step_nxt  = '0;
          state_nxt = sqsr_pkg::S_LIST;
        end else begin
          step_nxt  = '0;
          found_nxt = 1'b0;
          state_nxt = sqsr_pkg::S_SCAN;
        end
      end
      sqsr_pkg::S_SCAN: begin
        // full turn of the window; first match is captured at cell 0
        cmd.op   = sqsr_pkg::OP_ROTATE;
        step_nxt = step_r + CW'(1);
        if (!found_r && head == key_r) begin
          found_nxt = 1'b1;
          fpos_nxt  = step_r;
          fval_nxt  = head;
        end
        if (step_r == n - CW'(1)) state_nxt = sqsr_pkg::S_REPORT;
      end
      sqsr_pkg::S_REPORT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = sqsr_pkg::S_IDLE;
          if (found_r) begin
            out_position_nxt = sqsr_pkg::POS_W'(fpos_r);
            out_value_nxt    = fval_r;
            if (kind_r == sqsr_pkg::KIND_REMOVE) begin
              cmd.op  = sqsr_pkg::OP_REMOVE;
              cmd.arg = sqsr_pkg::ARG_W'(fpos_r);
            end
          end else begin
            out_status_nxt = sqsr_pkg::ST_NOT_FOUND;
          end
        end
      end
      sqsr_pkg::S_LIST: begin
        out_position_nxt = sqsr_pkg::POS_W'(step_r);
        out_value_nxt    = head;
        out_last_nxt     = (step_r == n - CW'(1));
        if (out_free) begin
          out_load = 1'b1;
          cmd.op   = sqsr_pkg::OP_ROTATE;
          step_nxt = step_r + CW'(1);
          if (out_last_nxt) state_nxt = sqsr_pkg::S_IDLE;
        end
      end
      default: state_nxt = sqsr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sqsr_pkg::S_IDLE;
      found_r     <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
      step_r  <= step_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    fpos_r <= fpos_nxt;
    fval_r <= fval_nxt;
    if (in_accept) begin
      kind_r <= sqsr_pkg::kind_t'(in_kind);
      sel_r  <= in_which_store;
      key_r  <= in_value;
    end
    if (out_load) begin
      out_status_r   <= out_status_nxt;
      out_position_r <= out_position_nxt;
      out_value_r    <= out_value_nxt;
      out_last_r     <= out_last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_position    = out_position_r;
  assign out_entry_value = out_value_r;
  assign out_last        = out_last_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stk_cnt <= FULL_CNT && que_cnt <= FULL_CNT)
    else $error("store count above depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && stk_cnt != $past(stk_cnt)) |->
      (stk_cnt == $past(stk_cnt) + CW'(1) || stk_cnt == $past(stk_cnt) - CW'(1)))
    else $error("stack count moved by more than one");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sqsr_pkg::S_SCAN || state_r == sqsr_pkg::S_LIST) |-> step_r < n)
    else $error("rotation step beyond entry count");

  a_list_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sqsr_pkg::S_LIST && out_load && out_last_nxt) |=>
      state_r == sqsr_pkg::S_IDLE)
    else $error("list did not finish after its last item");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == sqsr_pkg::S_EXEC)
    else $error("accepted item not executed");
`endif

endmodule

`default_nettype wire

FILE: test/tb_stack_queue_search_remove.sv
`timescale 1ns / 100ps
// Self-checking testbench for stack_queue_search_remove: random stall/valid
// traffic on both channels, results checked against a stack/queue tracker.
// Depends on sqsr_pkg and the RTL under hdl/.

typedef logic signed [sqsr_pkg::DATA_W-1:0] data_word_t;

typedef struct {
  sqsr_pkg::status_t          status;
  logic [sqsr_pkg::POS_W-1:0] position;
  data_word_t                 entry_value;
  logic                       last;
} store_result_t;

class store_tracker;
  data_word_t    stack_vals[$];  // index 0 is the stack top
  data_word_t    queue_vals[$];  // index 0 is the queue head
  store_result_t pending[$];
  int            errors;
  int            depth;

  function new(int depth_i);
    depth  = depth_i;
    errors = 0;
  endfunction

  function void push_result(sqsr_pkg::status_t st, int pos, data_word_t v, logic last);
    store_result_t r;
    r.status      = st;
    r.position    = pos[sqsr_pkg::POS_W-1:0];
    r.entry_value = v;
    r.last        = last;
    pending.push_back(r);
  endfunction

  // Random value currently held in a store, or a random word if it is empty.
  function data_word_t any_held(logic which);
    if (which == sqsr_pkg::STORE_QUEUE && queue_vals.size() != 0)
      return queue_vals[$urandom_range(0, queue_vals.size() - 1)];
    if (which == sqsr_pkg::STORE_STACK && stack_vals.size() != 0)
      return stack_vals[$urandom_range(0, stack_vals.size() - 1)];
    return $urandom;
  endfunction

  function void note_request(sqsr_pkg::kind_t k, logic which, data_word_t v);
    data_word_t held[$];
    int p;
    if (which == sqsr_pkg::STORE_QUEUE) held = queue_vals;
    else held = stack_vals;

    if (k == sqsr_pkg::KIND_ADD) begin
      if (held.size() >= depth) begin
        push_result(sqsr_pkg::ST_FULL, 0, '0, 1'b1);
      end else if (which == sqsr_pkg::STORE_QUEUE) begin
        held.push_back(v);
        push_result(sqsr_pkg::ST_OK, held.size() - 1, v, 1'b1);
      end else begin
        held.push_front(v);
        push_result(sqsr_pkg::ST_OK, 0, v, 1'b1);
      end
    end else if (held.size() == 0) begin
      push_result(sqsr_pkg::ST_EMPTY, 0, '0, 1'b1);
    end else if (k == sqsr_pkg::KIND_LIST) begin
      for (p = 0; p < held.size(); p++)
        push_result(sqsr_pkg::ST_OK, p, held[p], p == held.size() - 1);
    end else begin
      p = 0;
      while (p < held.size() && held[p] != v) p++;
      if (p == held.size()) begin
        push_result(sqsr_pkg::ST_NOT_FOUND, 0, '0, 1'b1);
      end else begin
        push_result(sqsr_pkg::ST_OK, p, held[p], 1'b1);
        if (k == sqsr_pkg::KIND_REMOVE) held.delete(p);
      end
    end

    if (which == sqsr_pkg::STORE_QUEUE) queue_vals = held;
    else stack_vals = held;
  endfunction

  function void check_result(logic [1:0] st, logic [sqsr_pkg::POS_W-1:0] pos,
                             data_word_t v, logic last);
    store_result_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result status=%0d position=%0d value=%0d last=%0b",
               $time, st, pos, v, last);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (st !== want.status) begin
      $display("%0t: status expected %0d got %0d", $time, want.status, st);
      errors++;
    end
    if (pos !== want.position) begin
      $display("%0t: position expected %0d got %0d", $time, want.position, pos);
      errors++;
    end
    if (v !== want.entry_value) begin
      $display("%0t: entry_value expected %0d got %0d", $time, want.entry_value, v);
      errors++;
    end
    if (last !== want.last) begin
      $display("%0t: last expected %0b got %0b", $time, want.last, last);
      errors++;
    end
  endfunction
endclass

module tb_stack_queue_search_remove;

  typedef enum int {PH_FILL, PH_MIX, PH_DRAIN} phase_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [1:0]                 in_kind;
  logic                       in_which_store;
  data_word_t                 in_value;
  logic                       out_valid;
  logic                       out_stall;
  logic [1:0]                 out_status;
  logic [sqsr_pkg::POS_W-1:0] out_position;
  data_word_t                 out_entry_value;
  logic                       out_last;

  store_tracker board;
  bit           steady_in;

  stack_queue_search_remove u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_which_store  (in_which_store),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_position    (out_position),
    .out_entry_value (out_entry_value),
    .out_last        (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(input sqsr_pkg::kind_t k, input logic which,
                           input data_word_t v);
    int gap;
    gap = steady_in ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= k;
    in_which_store <= which;
    in_value       <= v;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_request(k, which, v);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_status, out_position, out_entry_value, out_last);
  end

  // Result-side back-pressure, with occasional stall-free stretches.
  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      if ($urandom_range(0, 19) == 0) repeat ($urandom_range(30, 80)) @(posedge clk);
      n = idle_len();
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    phase_t          plan[4];
    int              plen[4];
    phase_t          mode;
    logic            favored;
    logic            which;
    sqsr_pkg::kind_t k;
    data_word_t      v;
    int              r;

    board = new(sqsr_pkg::DEPTH_DEF);
    plan  = '{PH_FILL, PH_MIX, PH_DRAIN, PH_FILL};
    plen  = '{25, 15, 15, 25};
    steady_in = 1'b0;

    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_kind        <= sqsr_pkg::KIND_ADD;
    in_which_store <= sqsr_pkg::STORE_STACK;
    in_value       <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Empty stores
    send_item(sqsr_pkg::KIND_LIST,   sqsr_pkg::STORE_STACK, 32'h0000_0007);
    send_item(sqsr_pkg::KIND_LIST,   sqsr_pkg::STORE_QUEUE, 32'hFFFF_FFFF);
    send_item(sqsr_pkg::KIND_REMOVE, sqsr_pkg::STORE_STACK, 32'h0000_0000);
    send_item(sqsr_pkg::KIND_FIND,   sqsr_pkg::STORE_QUEUE, 32'h0000_0000);
    // Extreme values
    send_item(sqsr_pkg::KIND_ADD, sqsr_pkg::STORE_STACK, 32'h8000_0000);
    send_item(sqsr_pkg::KIND_ADD, sqsr_pkg::STORE_STACK, 32'h7FFF_FFFF);
    send_item(sqsr_pkg::KIND_ADD, sqsr_pkg::STORE_STACK, 32'h0000_0000);
    send_item(sqsr_pkg::KIND_ADD, sqsr_pkg::STORE_STACK, 32'hFFFF_FFFF);
    send_item(sqsr_pkg::KIND_ADD, sqsr_pkg::STORE_QUEUE, 32'h8000_0000);
    send_item(sqsr_pkg::KIND_ADD, sqsr_pkg::STORE_QUEUE, 32'h7FFF_FFFF);
    send_item(sqsr_pkg::KIND_ADD, sqsr_pkg::STORE_QUEUE, 32'hFFFF_FFFF);
    // Hits, misses, removal from the middle and from the head
    send_item(sqsr_pkg::KIND_FIND,   sqsr_pkg::STORE_STACK, 32'h7FFF_FFFF);
    send_item(sqsr_pkg::KIND_FIND,   sqsr_pkg::STORE_STACK, 32'd12345);
    send_item(sqsr_pkg::KIND_REMOVE, sqsr_pkg::STORE_STACK, 32'h7FFF_FFFF);
    send_item(sqsr_pkg::KIND_REMOVE, sqsr_pkg::STORE_QUEUE, 32'h8000_0000);
    send_item(sqsr_pkg::KIND_FIND,   sqsr_pkg::STORE_QUEUE, 32'hFFFF_FFFF);
    send_item(sqsr_pkg::KIND_REMOVE, sqsr_pkg::STORE_QUEUE, 32'd5);
    send_item(sqsr_pkg::KIND_LIST,   sqsr_pkg::STORE_STACK, 32'h0000_0000);
    send_item(sqsr_pkg::KIND_LIST,   sqsr_pkg::STORE_QUEUE, 32'h0000_0000);
    // Duplicate: the copy nearest the top goes first
    send_item(sqsr_pkg::KIND_ADD,    sqsr_pkg::STORE_STACK, 32'h0000_0000);
    send_item(sqsr_pkg::KIND_REMOVE, sqsr_pkg::STORE_STACK, 32'h0000_0000);
    send_item(sqsr_pkg::KIND_LIST,   sqsr_pkg::STORE_STACK, 32'h0000_0000);

    // Random phases; the two fill phases target different stores so both
    // reach the full condition.
    favored = $urandom_range(0, 1);
    for (int ph = 0; ph < 4; ph++) begin
      mode      = plan[ph];
      steady_in = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < plen[ph]; i++) begin
        which = ($urandom_range(0, 9) < 8) ? favored : ~favored;
        r = $urandom_range(0, 99);
        case (mode)
          PH_FILL:  k = (r < 90) ? sqsr_pkg::KIND_ADD :
                        (r < 95) ? sqsr_pkg::KIND_FIND : sqsr_pkg::KIND_LIST;
          PH_MIX:   k = (r < 35) ? sqsr_pkg::KIND_ADD : (r < 60) ? sqsr_pkg::KIND_REMOVE :
                        (r < 85) ? sqsr_pkg::KIND_FIND : sqsr_pkg::KIND_LIST;
          default:  k = (r < 10) ? sqsr_pkg::KIND_ADD : (r < 70) ? sqsr_pkg::KIND_REMOVE :
                        (r < 85) ? sqsr_pkg::KIND_FIND : sqsr_pkg::KIND_LIST;
        endcase
        r = $urandom_range(0, 99);
        if (k == sqsr_pkg::KIND_ADD)
          v = (r < 30) ? data_word_t'($urandom_range(0, 4)) - 2 :
              (r < 50) ? board.any_held(which) : data_word_t'($urandom);
        else
          v = (r < 75) ? board.any_held(which) :
              (r < 85) ? data_word_t'($urandom_range(0, 4)) - 2 : data_word_t'($urandom);
        send_item(k, which, v);
      end
      favored = ~favored;
    end
    in_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
